// ===== hw/rtl/mck_pkg.sv =====
// ----------------------------------------------------------------------------
// mck_pkg
// Shared types, constants and the character pattern decoder of the keyer.
// ----------------------------------------------------------------------------
package mck_pkg;

  localparam int FIFO_DEPTH_DEF = 256;
  localparam int CHAR_W         = 8;
  localparam int TICK_W         = 16;
  localparam int CFG_ADDR_W     = 3;
  localparam int COUNT_W        = 9;
  localparam int OUT_TDATA_W    = 16;

  localparam logic [TICK_W-1:0] DOT_RST    = 16'd200;
  localparam logic [TICK_W-1:0] DASH_RST   = 16'd600;
  localparam logic [TICK_W-1:0] EGAP_RST   = 16'd200;
  localparam logic [TICK_W-1:0] LGAP_RST   = 16'd600;
  localparam logic [TICK_W-1:0] WGAP_RST   = 16'd1400;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UZ    = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LZ    = 8'h7A;
  localparam logic [CHAR_W-1:0] CHAR_D0    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_D9    = 8'h39;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_DOT  = 3'd0,
    REG_DASH = 3'd1,
    REG_EGAP = 3'd2,
    REG_LGAP = 3'd3,
    REG_WGAP = 3'd4
  } cfg_reg_t;

  // packed patterns: bits 4:0 elements (1 = dash), bits 7:5 length
  localparam logic [7:0] LETTER_PAT [26] = '{
    8'h42, 8'h81, 8'h85, 8'h61, 8'h20, 8'h84, 8'h63, 8'h80, 8'h40, 8'h8E,
    8'h65, 8'h82, 8'h43, 8'h41, 8'h67, 8'h86, 8'h8B, 8'h62, 8'h60, 8'h21,
    8'h64, 8'h88, 8'h66, 8'h89, 8'h8D, 8'h83
  };

  localparam logic [7:0] DIGIT_PAT [10] = '{
    8'hBF, 8'hBE, 8'hBC, 8'hB8, 8'hB0, 8'hA0, 8'hA1, 8'hA3, 8'hA7, 8'hAF
  };

  typedef struct packed {
    logic       valid;
    logic [4:0] bits;
    logic [2:0] total;
  } mck_pat_t;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic [CHAR_W-1:0] wdata;
  } mck_fifo_req_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [CHAR_W-1:0] head;
  } mck_fifo_st_t;

  typedef struct packed {
    logic busy;
    logic accepted;
    logic key;
  } mck_flags_t;

  typedef struct packed {
    logic [COUNT_W-1:0] queued_count;
    logic               busy_res;
    logic               accepted;
    logic               key_on;
  } mck_result_t;

  function automatic mck_pat_t mck_decode(input logic [CHAR_W-1:0] c);
    mck_pat_t   p;
    logic [7:0] raw;
    logic [7:0] off;
    p   = '0;
    raw = '0;
    off = '0;
    if (c >= CHAR_UA && c <= CHAR_UZ) begin
      off     = c - CHAR_UA;
      raw     = LETTER_PAT[off[4:0]];
      p.valid = 1'b1;
    end else if (c >= CHAR_LA && c <= CHAR_LZ) begin
      off     = c - CHAR_LA;
      raw     = LETTER_PAT[off[4:0]];
      p.valid = 1'b1;
    end else if (c >= CHAR_D0 && c <= CHAR_D9) begin
      off     = c - CHAR_D0;
      raw     = DIGIT_PAT[off[3:0]];
      p.valid = 1'b1;
    end
    p.bits  = raw[4:0];
    p.total = raw[7:5];
    return p;
  endfunction

  function automatic logic [TICK_W-1:0] mck_dur(input logic [TICK_W-1:0] v);
    return (v == '0) ? TICK_W'(1) : v;
  endfunction

endpackage

// ===== hw/rtl/mck_fifo.sv =====
// ----------------------------------------------------------------------------
// mck_fifo
// Character queue in a synchronous RAM; the head entry is read ahead into a
// register every cycle, with write forwarding, so a pop sees it at once.
// ----------------------------------------------------------------------------
module mck_fifo
  import mck_pkg::*;
#(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mck_fifo_req_t      req,
  output mck_fifo_st_t       st,
  output logic [COUNT_W-1:0] queued_nxt
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  logic [CHAR_W-1:0] mem_r [FIFO_DEPTH];
  logic [CHAR_W-1:0] head_r;
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [CNT_W+COUNT_W-1:0] fill_ext;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (req.push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      fill_nxt   = fill_r + CNT_W'(1);
    end
    if (req.pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      fill_nxt   = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.push) begin
      mem_r[wr_ptr_r] <= req.wdata;
    end
  end

  // read ahead at the next head address; forward a write to that same entry
  always_ff @(posedge clk) begin
    if (req.push && wr_ptr_r == rd_ptr_nxt) begin
      head_r <= req.wdata;
    end else begin
      head_r <= mem_r[rd_ptr_nxt];
    end
  end

  assign st.full    = (fill_r == CNT_W'(FIFO_DEPTH));
  assign st.empty   = (fill_r == '0);
  assign st.head    = head_r;
  assign fill_ext   = {{COUNT_W{1'b0}}, fill_nxt};
  assign queued_nxt = fill_ext[COUNT_W-1:0];

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    req.push |-> !st.full) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    req.pop |-> !st.empty) else $error("pop from empty queue");
`endif

endmodule

// ===== hw/rtl/mck_seq.sv =====
// ----------------------------------------------------------------------------
// mck_seq
// Keyer sequencer: timing registers, countdown and element stepping.
// ----------------------------------------------------------------------------
module mck_seq
  import mck_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [TICK_W-1:0]     cfg_wdata,
  input  logic                  step,
  input  logic                  mode,
  input  logic [CHAR_W-1:0]     char_code,
  input  mck_fifo_st_t          fst,
  output mck_fifo_req_t         freq,
  output mck_flags_t            flags
);

  logic [TICK_W-1:0] dot_r, dash_r, egap_r, lgap_r, wgap_r;
  logic              sending_r, sending_nxt;
  logic [TICK_W-1:0] ticks_r, ticks_nxt;
  logic              letter_r, letter_nxt;
  logic [4:0]        bits_r, bits_nxt;
  logic [2:0]        total_r, total_nxt;
  logic [2:0]        idx_r, idx_nxt;
  logic              key_r, key_nxt;
  logic              accepted;
  logic              dash;
  logic [7:0]        bits_ext;
  mck_pat_t          pat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r  <= DOT_RST;
      dash_r <= DASH_RST;
      egap_r <= EGAP_RST;
      lgap_r <= LGAP_RST;
      wgap_r <= WGAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_DOT:  dot_r  <= cfg_wdata;
        REG_DASH: dash_r <= cfg_wdata;
        REG_EGAP: egap_r <= cfg_wdata;
        REG_LGAP: lgap_r <= cfg_wdata;
        REG_WGAP: wgap_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign pat      = mck_decode(fst.head);
  assign bits_ext = {3'b000, bits_r};
  assign dash     = bits_ext[idx_r];

  always_comb begin
    sending_nxt = sending_r;
    ticks_nxt   = ticks_r;
    letter_nxt  = letter_r;
    bits_nxt    = bits_r;
    total_nxt   = total_r;
    idx_nxt     = idx_r;
    key_nxt     = key_r;
    accepted    = 1'b0;
    freq.push   = 1'b0;
    freq.pop    = 1'b0;
    freq.wdata  = char_code;
    if (step) begin
      if (mode == MODE_WRITE) begin
        if (!fst.full) begin
          freq.push = 1'b1;
          accepted  = 1'b1;
        end
        if (!sending_r && (!fst.full || !fst.empty)) begin
          sending_nxt = 1'b1;
          ticks_nxt   = TICK_W'(1);
        end
      end else if (sending_r) begin
        if (ticks_r > TICK_W'(1)) begin
          ticks_nxt = ticks_r - TICK_W'(1);
        end else if (!letter_r) begin
          // load the next character
          if (fst.empty) begin
            sending_nxt = 1'b0;
            key_nxt     = 1'b0;
            ticks_nxt   = '0;
          end else begin
            freq.pop = 1'b1;
            if (pat.valid) begin
              bits_nxt   = pat.bits;
              total_nxt  = pat.total;
              idx_nxt    = '0;
              letter_nxt = 1'b1;
              ticks_nxt  = TICK_W'(1);
            end else if (fst.head == CHAR_SPACE) begin
              key_nxt   = 1'b0;
              ticks_nxt = mck_dur(wgap_r);
            end else begin
              ticks_nxt = TICK_W'(1);
            end
          end
        end else if (key_r) begin
          key_nxt   = 1'b0;
          ticks_nxt = mck_dur(egap_r);
        end else if (idx_r >= total_r) begin
          letter_nxt = 1'b0;
          ticks_nxt  = mck_dur(lgap_r);
        end else begin
          key_nxt   = 1'b1;
          ticks_nxt = dash ? mck_dur(dash_r) : mck_dur(dot_r);
          idx_nxt   = idx_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sending_r <= 1'b0;
      ticks_r   <= '0;
      letter_r  <= 1'b0;
      bits_r    <= '0;
      total_r   <= '0;
      idx_r     <= '0;
      key_r     <= 1'b0;
    end else begin
      sending_r <= sending_nxt;
      ticks_r   <= ticks_nxt;
      letter_r  <= letter_nxt;
      bits_r    <= bits_nxt;
      total_r   <= total_nxt;
      idx_r     <= idx_nxt;
      key_r     <= key_nxt;
    end
  end

  assign flags.busy     = sending_nxt;
  assign flags.accepted = accepted;
  assign flags.key      = key_nxt;

`ifndef NO_ASSERTIONS
  a_key_in_letter: assert property (@(posedge clk) disable iff (!rst_n)
    key_r |-> letter_r) else $error("key on outside a letter");
  a_letter_sending: assert property (@(posedge clk) disable iff (!rst_n)
    letter_r |-> sending_r) else $error("letter active while idle");
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    letter_r |-> (idx_r <= total_r && total_r <= 3'd5))
    else $error("element index past letter length");
`endif

endmodule

// ===== hw/rtl/mck_out.sv =====
// ----------------------------------------------------------------------------
// mck_out
// Two-entry result buffer: output register plus skid register, so the input
// side keeps taking requests while a result waits on the receiver.
// ----------------------------------------------------------------------------
module mck_out
  import mck_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  mck_result_t res,
  output logic        ready,
  output logic        out_valid,
  input  logic        out_ready,
  output mck_result_t out_res
);

  logic        main_vld_r, skid_vld_r;
  mck_result_t main_r, skid_r;
  logic        pop;

  assign pop       = main_vld_r && out_ready;
  assign ready     = !skid_vld_r;
  assign out_valid = main_vld_r;
  assign out_res   = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (pop) begin
      if (skid_vld_r) begin
        skid_vld_r <= 1'b0;
      end else begin
        main_vld_r <= push;
      end
    end else if (push) begin
      if (main_vld_r) begin
        skid_vld_r <= 1'b1;
      end else begin
        main_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      main_r <= skid_vld_r ? skid_r : res;
    end else if (push) begin
      if (main_vld_r) begin
        skid_r <= res;
      end else begin
        main_r <= res;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> main_vld_r) else $error("skid holds result ahead of output");
`endif

endmodule

// ===== hw/rtl/morse_code_keyer_unit.sv =====
// ----------------------------------------------------------------------------
// morse_code_keyer_unit
// Morse keyer: queues characters and steps key timing on tick requests.
// ----------------------------------------------------------------------------
// Input channel: in_tuser selects the request kind (0 = queue in_tdata as an
// ASCII character, 1 = one time tick). Every request gives exactly one result
// on the output channel: key level, whether the character was stored, busy,
// and the queue fill after the request.
// Throughput is one request per cycle while in_tready is high, and results are
// registered. The queue lives in one RAM with a registered read; its head is
// read ahead every cycle with write forwarding, so a character load on tick
// expiry does not wait for a RAM read. The user must write the timing
// registers through cfg_we/cfg_addr/cfg_wdata only while idle; the block itself
// does not enforce this. Reset restores the default timings, empties the queue
// (RAM contents are left as they are) and turns the key off. When the receiver
// stalls, up to two results are held; in_tready drops while both are held.
// ----------------------------------------------------------------------------
module morse_code_keyer_unit
  import mck_pkg::*;
#(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [CHAR_W-1:0]      in_tdata,   // [7:0] char_code
  input  logic                   in_tuser,   // [0] mode
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [0] key_on, [1] accepted,
                                             // [2] busy_res, [11:3] queued_count
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [TICK_W-1:0]      cfg_wdata
);

  logic               step;
  mck_fifo_req_t      freq;
  mck_fifo_st_t       fst;
  mck_flags_t         flags;
  logic [COUNT_W-1:0] queued_nxt;
  mck_result_t        res;
  mck_result_t        out_res;

  assign step = in_tvalid && in_tready;

  mck_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (freq),
    .st         (fst),
    .queued_nxt (queued_nxt)
  );

  mck_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .mode      (in_tuser),
    .char_code (in_tdata),
    .fst       (fst),
    .freq      (freq),
    .flags     (flags)
  );

  assign res.queued_count = queued_nxt;
  assign res.busy_res     = flags.busy;
  assign res.accepted     = flags.accepted;
  assign res.key_on       = flags.key;

  mck_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step),
    .res       (res),
    .ready     (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {{(OUT_TDATA_W - $bits(mck_result_t)){1'b0}}, out_res};

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Morse keyer: character and tick requests,
// timing register programming, and a per-request status check.
// ----------------------------------------------------------------------------
// A tracker class predicts the status of every accepted request: it keeps its
// own character queue, countdown and element sequencer. The status is checked
// field by field as it leaves the block. The sender runs in random bursts. The
// receiver stalls in windows of varying density. Timing is reprogrammed
// between phases: directed characters, random traffic, a queue overflow and
// the largest durations.
// ----------------------------------------------------------------------------
module testbench;
  import mck_pkg::*;

  localparam int QDEPTH      = FIFO_DEPTH_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam int ADDR_SPAN   = 2 ** CFG_ADDR_W;

  class keyer_tracker;
    logic [TICK_W-1:0] dot_len, dash_len, egap_len, lgap_len, wgap_len;
    logic [CHAR_W-1:0] queue_mem [QDEPTH];
    int                head, tail, fill;
    bit                sending, in_letter, key;
    int                ticks_left, elem;
    string             pattern;
    string             letter_code [26];
    string             digit_code [10];
    mck_result_t       expected_status [$];
    int                mismatches;

    function new();
      dot_len     = DOT_RST;
      dash_len    = DASH_RST;
      egap_len    = EGAP_RST;
      lgap_len    = LGAP_RST;
      wgap_len    = WGAP_RST;
      head        = 0;
      tail        = 0;
      fill        = 0;
      sending     = 0;
      in_letter   = 0;
      key         = 0;
      ticks_left  = 0;
      elem        = 0;
      pattern     = "";
      mismatches  = 0;
      letter_code = '{".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
                      ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
                      "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--.."};
      digit_code  = '{"-----", ".----", "..---", "...--", "....-",
                      ".....", "-....", "--...", "---..", "----."};
    endfunction

    // a zero register still holds for one tick
    function int span(logic [TICK_W-1:0] v);
      return (v == '0) ? 1 : int'(v);
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] addr, logic [TICK_W-1:0] v);
      case (addr)
        REG_DOT:  dot_len  = v;
        REG_DASH: dash_len = v;
        REG_EGAP: egap_len = v;
        REG_LGAP: lgap_len = v;
        REG_WGAP: wgap_len = v;
        default: ;
      endcase
    endfunction

    function void expire();
      logic [CHAR_W-1:0] c;
      if (!in_letter) begin
        if (fill == 0) begin
          sending    = 0;
          key        = 0;
          ticks_left = 0;
          return;
        end
        c    = queue_mem[head];
        head = (head + 1) % QDEPTH;
        fill--;
        if ((c >= CHAR_UA && c <= CHAR_UZ) || (c >= CHAR_LA && c <= CHAR_LZ) ||
            (c >= CHAR_D0 && c <= CHAR_D9)) begin
          if (c >= CHAR_UA && c <= CHAR_UZ) begin
            pattern = letter_code[c - CHAR_UA];
          end else if (c >= CHAR_LA && c <= CHAR_LZ) begin
            pattern = letter_code[c - CHAR_LA];
          end else begin
            pattern = digit_code[c - CHAR_D0];
          end
          elem       = 0;
          in_letter  = 1;
          ticks_left = 1;
        end else if (c == CHAR_SPACE) begin
          key        = 0;
          ticks_left = span(wgap_len);
        end else begin
          ticks_left = 1;
        end
      end else if (key) begin
        key        = 0;
        ticks_left = span(egap_len);
      end else if (elem >= pattern.len()) begin
        in_letter  = 0;
        ticks_left = span(lgap_len);
      end else begin
        key        = 1;
        ticks_left = (pattern[elem] == "-") ? span(dash_len) : span(dot_len);
        elem++;
      end
    endfunction

    function void take_request(logic mode, logic [CHAR_W-1:0] ch);
      mck_result_t s;
      bit          stored;
      stored = 0;
      if (mode == MODE_WRITE) begin
        if (fill < QDEPTH) begin
          queue_mem[tail] = ch;
          tail            = (tail + 1) % QDEPTH;
          fill++;
          stored = 1;
        end
        if (!sending && fill > 0) begin
          sending    = 1;
          ticks_left = 1;
        end
      end else if (sending) begin
        if (ticks_left > 1) begin
          ticks_left--;
        end else begin
          ticks_left = 0;
          expire();
        end
      end
      s.key_on       = key;
      s.accepted     = stored;
      s.busy_res     = sending;
      s.queued_count = COUNT_W'(fill);
      expected_status.push_back(s);
    endfunction

    task report(input string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_status(input logic [OUT_TDATA_W-1:0] data);
      mck_result_t got, want;
      got = data[$bits(mck_result_t)-1:0];
      if (expected_status.size() == 0) begin
        report($sformatf("status %h with no request pending", data));
        return;
      end
      want = expected_status.pop_front();
      if (got.key_on !== want.key_on)
        report($sformatf("key_on %b, want %b", got.key_on, want.key_on));
      if (got.accepted !== want.accepted)
        report($sformatf("accepted %b, want %b", got.accepted, want.accepted));
      if (got.busy_res !== want.busy_res)
        report($sformatf("busy_res %b, want %b", got.busy_res, want.busy_res));
      if (got.queued_count !== want.queued_count)
        report($sformatf("queued_count %0d, want %0d", got.queued_count,
                         want.queued_count));
      if (data[OUT_TDATA_W-1:$bits(mck_result_t)] !== '0)
        report($sformatf("padding bits set in %h", data));
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [CHAR_W-1:0]      in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [TICK_W-1:0]      cfg_wdata;

  keyer_tracker tracker;
  int           idle_cycles = 0;
  int           burst_left  = 0;
  int           stall_window = 0;
  int           stall_style  = 0;

  morse_code_keyer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: windows of always-ready, coin-flip and mostly-stalled
  always @(negedge clk) begin
    if (stall_window == 0) begin
      stall_style  = $urandom_range(0, 3);
      stall_window = $urandom_range(4, 64);
    end
    stall_window--;
    case (stall_style)
      2:       out_tready <= 1'($urandom_range(0, 1));
      3:       out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= 1'b1;
    endcase
  end

  // check the outgoing status before noting the incoming request
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) tracker.check_status(out_tdata);
      if (in_tvalid && in_tready) tracker.take_request(in_tuser, in_tdata);
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready) || cfg_we) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("[morse_code_keyer_unit] ERROR");
    $finish;
  end

  task automatic send_request(input logic mode, input logic [CHAR_W-1:0] ch);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 3);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= ch;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // hold off the sender until every status has come back
  task automatic settle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (tracker.expected_status.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic program_timing(input logic [TICK_W-1:0] dot, dash, egap, lgap, wgap);
    logic [TICK_W-1:0] vals [ADDR_SPAN];
    vals[REG_DOT]  = dot;
    vals[REG_DASH] = dash;
    vals[REG_EGAP] = egap;
    vals[REG_LGAP] = lgap;
    vals[REG_WGAP] = wgap;
    // unmapped indexes get junk that must be dropped
    for (int a = REG_WGAP + 1; a < ADDR_SPAN; a++) vals[a] = TICK_W'($urandom);
    for (int a = 0; a < ADDR_SPAN; a++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= CFG_ADDR_W'(a);
      cfg_wdata <= vals[a];
      tracker.set_reg(CFG_ADDR_W'(a), vals[a]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic drain_keyer();
    while (tracker.sending) send_request(MODE_TICK, CHAR_W'($urandom));
  endtask

  function automatic logic [CHAR_W-1:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1, 2: return CHAR_W'(CHAR_UA + $urandom_range(0, 25));
      3, 4, 5: return CHAR_W'(CHAR_LA + $urandom_range(0, 25));
      6:       return CHAR_W'(CHAR_D0 + $urandom_range(0, 9));
      7:       return CHAR_SPACE;
      default: return CHAR_W'($urandom);
    endcase
  endfunction

  function automatic logic [TICK_W-1:0] pick_len();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return TICK_W'(1);
      2:       return TICK_W'($urandom_range(2, 40));
      default: return TICK_W'($urandom_range(1, 4));
    endcase
  endfunction

  task automatic run_mix(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 149) == 0) settle();
      if ($urandom_range(0, 99) < 28) begin
        send_request(MODE_WRITE, pick_char());
      end else begin
        send_request(MODE_TICK, CHAR_W'($urandom));
      end
    end
  endtask

  initial begin
    logic [CHAR_W-1:0] directed [$];
    tracker   = new();
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = MODE_WRITE;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed: boundaries of every character class, then play it all out
    program_timing('0, TICK_W'(2), TICK_W'(1), TICK_W'(1), TICK_W'(3));
    send_request(MODE_TICK, 8'hFF);
    send_request(MODE_TICK, 8'h00);
    directed = '{CHAR_UA, CHAR_LZ, CHAR_D0, CHAR_D9, CHAR_SPACE, 8'h00, 8'hFF,
                 CHAR_UZ, CHAR_LA, CHAR_UA - 8'd1, CHAR_UZ + 8'd1, CHAR_LA - 8'd1,
                 CHAR_LZ + 8'd1, CHAR_D0 - 8'd1, CHAR_D9 + 8'd1};
    foreach (directed[i]) send_request(MODE_WRITE, directed[i]);
    drain_keyer();
    settle();

    // random traffic; queued characters carry over into the next timing set
    repeat (4) begin
      program_timing(pick_len(), pick_len(), pick_len(), pick_len(), pick_len());
      run_mix(25);
      settle();
    end

    // play out what is left with the shortest timing
    program_timing(TICK_W'(1), TICK_W'(1), TICK_W'(1), TICK_W'(1), TICK_W'(1));
    drain_keyer();
    settle();

    // overflow: fill the queue, get refused, free an entry with ticks, refill
    repeat (QDEPTH + 2) send_request(MODE_WRITE, CHAR_W'($urandom));
    repeat (12) send_request(MODE_TICK, CHAR_W'($urandom));
    send_request(MODE_WRITE, pick_char());
    send_request(MODE_WRITE, pick_char());
    settle();

    // longest durations: count partway down a long element
    program_timing('1, '1, '1, '1, '1);
    send_request(MODE_WRITE, CHAR_UA + 8'd16);
    send_request(MODE_WRITE, CHAR_D0 + 8'd5);
    send_request(MODE_WRITE, CHAR_SPACE);
    repeat (40) send_request(MODE_TICK, CHAR_W'($urandom));

    in_tvalid <= 1'b0;
    while (tracker.expected_status.size() != 0) @(negedge clk);
    repeat (16) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("[morse_code_keyer_unit] OK");
    end else begin
      $display("[morse_code_keyer_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/mck_pkg.sv
hw/rtl/mck_fifo.sv
hw/rtl/mck_seq.sv
hw/rtl/mck_out.sv
hw/rtl/morse_code_keyer_unit.sv
test/testbench.sv
